[design/button_click_mode_selector_top_macros.svh]
// Assertion macros used by the button click mode selector top level.
`ifndef BUTTON_CLICK_MODE_SELECTOR_TOP_MACROS_SVH
`define BUTTON_CLICK_MODE_SELECTOR_TOP_MACROS_SVH

// Check a property on every clock edge outside reset.
`define BCMS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define BCMS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[design/bcms_pkg.sv]
// Shared types and constants for the button click mode selector.
`default_nettype none

package bcms_pkg;

  localparam int unsigned TimeW  = 32;
  localparam int unsigned CfgW   = 16;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned KindW  = 3;
  localparam int unsigned ModeW  = 2;
  localparam int unsigned CountW = 2;

  localparam logic [CfgW-1:0] LongPressReset = CfgW'(3000);
  localparam logic [CfgW-1:0] WindowReset    = CfgW'(500);

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgLongPress = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgWindow    = CfgIdxW'(1);

  typedef enum logic [KindW-1:0] {
    KindNone   = 3'd0,
    KindSingle = 3'd1,
    KindDouble = 3'd2,
    KindTriple = 3'd3,
    KindLong   = 3'd4
  } kind_e;

  typedef enum logic [ModeW-1:0] {
    ModeDebug    = 2'd0,
    ModeTracking = 2'd1,
    ModeSleep    = 2'd2
  } mode_e;

  // One registered sample handed to the classifier
  typedef struct packed {
    logic             fire;
    logic             level;
    logic [TimeW-1:0] now;
  } sample_t;

endpackage

`default_nettype wire

[design/bcms_classify.sv]
// Press tracking state and click / long-press classification.
`default_nettype none

module bcms_classify (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  bcms_pkg::sample_t          sample_i,
  input  logic [bcms_pkg::CfgW-1:0]  long_ms_i,
  input  logic [bcms_pkg::CfgW-1:0]  win_ms_i,
  output bcms_pkg::kind_e            kind_o
);
  import bcms_pkg::*;

  logic              held_q, held_d;
  logic              long_rep_q, long_rep_d;
  logic [TimeW-1:0]  start_q, start_d;
  logic [TimeW-1:0]  last_rel_q, last_rel_d;
  logic [CountW-1:0] count_q, count_d;

  logic              press_start;
  logic              release_hit;
  logic [TimeW-1:0]  hold_dur;
  logic [TimeW-1:0]  gap;
  logic              long_hit;
  logic              in_window;
  logic              window_expired;

  // Edge detection and elapsed times, all modulo 2^32
  assign press_start    = ~sample_i.level & ~held_q;
  assign release_hit    = sample_i.level & held_q;
  assign hold_dur       = sample_i.now - start_q;
  assign gap            = sample_i.now - last_rel_q;
  assign long_hit       = hold_dur >= {{(TimeW-CfgW){1'b0}}, long_ms_i};
  assign in_window      = gap < {{(TimeW-CfgW){1'b0}}, win_ms_i};
  assign window_expired = gap > {{(TimeW-CfgW){1'b0}}, win_ms_i};

  // Classify the sample and work out the next tracking state
  always_comb begin
    held_d     = held_q;
    long_rep_d = long_rep_q;
    start_d    = start_q;
    last_rel_d = last_rel_q;
    count_d    = count_q;
    kind_o     = KindNone;

    if (press_start) begin
      held_d     = 1'b1;
      start_d    = sample_i.now;
      long_rep_d = 1'b0;
    end

    if (release_hit) begin
      held_d = 1'b0;
      if (long_rep_q) begin
        kind_o = KindNone;
      end else if (long_hit) begin
        count_d = '0;
        kind_o  = KindLong;
      end else begin
        if (in_window) begin
          if (count_q != '1) begin
            count_d = count_q + CountW'(1);
          end
        end else begin
          count_d = CountW'(1);
        end
        last_rel_d = sample_i.now;
        kind_o     = kind_e'({1'b0, count_d});
      end
    end else begin
      // Drop a stale click count once the window has run out
      if (!held_d && (count_q != '0) && window_expired) begin
        count_d = '0;
      end
      // Report a long hold once while still pressed
      if (held_d && !long_rep_d &&
          (press_start ? (long_ms_i == '0) : long_hit)) begin
        long_rep_d = 1'b1;
        count_d    = '0;
        kind_o     = KindLong;
      end
    end
  end

  // Advance the tracking state on each processed beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q     <= 1'b0;
      long_rep_q <= 1'b0;
      start_q    <= '0;
      last_rel_q <= '0;
      count_q    <= '0;
    end else if (sample_i.fire) begin
      held_q     <= held_d;
      long_rep_q <= long_rep_d;
      start_q    <= start_d;
      last_rel_q <= last_rel_d;
      count_q    <= count_d;
    end
  end

endmodule

`default_nettype wire

[design/bcms_mode.sv]
// Mode register driven by the reported press kind.
`default_nettype none

module bcms_mode (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  bcms_pkg::kind_e  kind_i,
  output bcms_pkg::mode_e  mode_o,
  output logic             changed_o
);
  import bcms_pkg::*;

  mode_e mode_q, mode_d;

  // Select the next mode from the press kind
  always_comb begin
    mode_d = mode_q;
    case (kind_i)
      KindSingle: begin
        if (mode_q == ModeDebug) begin
          mode_d = ModeTracking;
        end else if (mode_q == ModeTracking) begin
          mode_d = ModeDebug;
        end
      end
      KindDouble: mode_d = ModeSleep;
      KindTriple: mode_d = ModeDebug;
      KindLong:   mode_d = ModeDebug;
      default:    mode_d = mode_q;
    endcase
  end

  assign mode_o    = mode_d;
  assign changed_o = (mode_d != mode_q);

  // Hold the mode between processed beats
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeDebug;
    end else if (fire_i) begin
      mode_q <= mode_d;
    end
  end

endmodule

`default_nettype wire

[design/button_click_mode_selector_top.sv]
// Each accepted beat is held in the input register, then moves into the result register.
// Throughput: one beat per cycle while the result channel is not stalled; the press
//   state and mode update between the input register and the result register.
// The input register stalls only while the result register is full and stalled.
// Reset (async, active low): press state and mode clear to idle / debug,
//   thresholds load 3000 ms and 500 ms.
`default_nettype none

`include "button_click_mode_selector_top_macros.svh"

module button_click_mode_selector_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Sample channel
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           button_level_i,
  input  logic [bcms_pkg::TimeW-1:0]     now_ms_i,
  // Result channel
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [bcms_pkg::KindW-1:0]     press_kind_o,
  output logic [bcms_pkg::ModeW-1:0]     mode_o,
  output logic                           mode_changed_o,
  // Configuration write channel
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [bcms_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [bcms_pkg::CfgW-1:0]      cfg_data_i
);
  import bcms_pkg::*;

  logic             in_valid_q;
  logic             in_level_q;
  logic [TimeW-1:0] in_now_q;
  logic             advance;
  logic             proc;

  logic [CfgW-1:0]  long_ms_q;
  logic [CfgW-1:0]  win_ms_q;

  sample_t          sample;
  kind_e            kind;
  mode_e            mode_next;
  logic             changed;

  logic             out_valid_q;
  logic [KindW-1:0] kind_q;
  logic [ModeW-1:0] mode_q;
  logic             changed_q;

  // Configuration writes are always taken
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_ms_q <= LongPressReset;
      win_ms_q  <= WindowReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgLongPress: long_ms_q <= cfg_data_i;
        CfgWindow:    win_ms_q  <= cfg_data_i;
        default:      ;
      endcase
    end
  end

  // Move the held beat forward when the result register is free
  assign advance    = ~out_valid_q | ~out_stall_i;
  assign proc       = in_valid_q & advance;
  assign in_stall_o = in_valid_q & ~advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_level_q <= button_level_i;
      in_now_q   <= now_ms_i;
    end
  end

  assign sample.fire  = proc;
  assign sample.level = in_level_q;
  assign sample.now   = in_now_q;

  bcms_classify u_classify (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .sample_i  (sample),
    .long_ms_i (long_ms_q),
    .win_ms_i  (win_ms_q),
    .kind_o    (kind)
  );

  bcms_mode u_mode (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (proc),
    .kind_i    (kind),
    .mode_o    (mode_next),
    .changed_o (changed)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc) begin
      kind_q    <= kind;
      mode_q    <= mode_next;
      changed_q <= changed;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign press_kind_o   = kind_q;
  assign mode_o         = mode_q;
  assign mode_changed_o = changed_q;

  `BCMS_ASSERT_ALWAYS(a_stall_only_when_full,
    in_stall_o |-> (out_valid_o && out_stall_i),
    "input stalled while result register can take a beat")
  `BCMS_ASSERT(a_proc_fills_output, proc |=> out_valid_o,
    "processed beat did not reach the result register")
  `BCMS_ASSERT(a_double_selects_sleep,
    (out_valid_o && press_kind_o == KindDouble) |-> (mode_o == ModeSleep),
    "double press without sleep mode")
  `BCMS_ASSERT(a_triple_long_select_debug,
    (out_valid_o && (press_kind_o == KindTriple || press_kind_o == KindLong))
      |-> (mode_o == ModeDebug),
    "triple or long press without debug mode")

endmodule

`default_nettype wire

[tb/sv/button_click_mode_selector_top_tb.sv]
// Testbench for the button click mode selector: directed and random samples, locally predicted.
`timescale 1ns / 1ps

module button_click_mode_selector_top_tb;
  import bcms_pkg::*;

  // Spare register slots that the block must ignore
  localparam logic [CfgIdxW-1:0] CfgSpareLo = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] CfgSpareHi = CfgIdxW'(3);
  localparam logic [CountW-1:0]  CountMax   = CountW'(3);
  localparam int unsigned        DrainCycles = 10;
  localparam int unsigned        ItemsPerPhase = 80;

  typedef struct {
    kind_e kind;
    mode_e mode;
    logic  changed;
  } outcome_t;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  logic              button_level_i;
  logic [TimeW-1:0]  now_ms_i;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [KindW-1:0]  press_kind_o;
  logic [ModeW-1:0]  mode_o;
  logic              mode_changed_o;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [CfgW-1:0]   cfg_data_i;

  // Local copy of the detector state and thresholds
  logic              held_q = 1'b0;
  logic              long_seen_q = 1'b0;
  logic [TimeW-1:0]  press_start_q = '0;
  logic [TimeW-1:0]  last_release_q = '0;
  logic [CountW-1:0] clicks_q = '0;
  mode_e             mode_q = ModeDebug;
  logic [CfgW-1:0]   long_ms_q = LongPressReset;
  logic [CfgW-1:0]   window_ms_q = WindowReset;

  outcome_t          due_outcomes[$];
  int unsigned       mismatch_count = 0;
  int unsigned       sent_count = 0;
  int unsigned       idle_pct = 0;
  int unsigned       stall_pct = 0;
  logic [TimeW-1:0]  t_ms = '0;

  button_click_mode_selector_top u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .button_level_i (button_level_i),
    .now_ms_i       (now_ms_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .press_kind_o   (press_kind_o),
    .mode_o         (mode_o),
    .mode_changed_o (mode_changed_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Classify one sample and advance the press state
  function automatic kind_e classify_sample(logic level, logic [TimeW-1:0] now);
    logic [TimeW-1:0] hold_ms;
    logic [TimeW-1:0] gap_ms;
    if (!level && !held_q) begin
      held_q = 1'b1;
      press_start_q = now;
      long_seen_q = 1'b0;
    end
    hold_ms = now - press_start_q;
    gap_ms = now - last_release_q;
    if (level && held_q) begin
      held_q = 1'b0;
      if (long_seen_q) return KindNone;
      if (hold_ms >= long_ms_q) begin
        clicks_q = '0;
        return KindLong;
      end
      if (gap_ms < window_ms_q) begin
        if (clicks_q != CountMax) clicks_q = clicks_q + CountW'(1);
      end else begin
        clicks_q = CountW'(1);
      end
      last_release_q = now;
      case (clicks_q)
        CountW'(1): return KindSingle;
        CountW'(2): return KindDouble;
        default:    return KindTriple;
      endcase
    end
    // Drop a stale click count once the window has run out
    if (!held_q && clicks_q != '0 && gap_ms > window_ms_q) clicks_q = '0;
    if (held_q && !long_seen_q && hold_ms >= long_ms_q) begin
      long_seen_q = 1'b1;
      clicks_q = '0;
      return KindLong;
    end
    return KindNone;
  endfunction

  // Work out the result beat for one sample, mode update included
  function automatic outcome_t predict_outcome(logic level, logic [TimeW-1:0] now);
    outcome_t res;
    mode_e prior;
    prior = mode_q;
    res.kind = classify_sample(level, now);
    case (res.kind)
      KindSingle: begin
        if (mode_q == ModeDebug) mode_q = ModeTracking;
        else if (mode_q == ModeTracking) mode_q = ModeDebug;
      end
      KindDouble: mode_q = ModeSleep;
      KindTriple, KindLong: mode_q = ModeDebug;
      default: ;
    endcase
    res.mode = mode_q;
    res.changed = (mode_q != prior);
    return res;
  endfunction

  // Drive one sample beat and record its outcome once accepted
  task automatic send_sample(input logic level, input logic [TimeW-1:0] now);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    button_level_i <= level;
    now_ms_i <= now;
    do @(posedge clk_i); while (in_stall_o);
    due_outcomes.push_back(predict_outcome(level, now));
    sent_count++;
  endtask

  // Hold off the sender until every result beat has come back
  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (due_outcomes.size() != 0);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CfgLongPress: long_ms_q = data;
      CfgWindow:    window_ms_q = data;
      default: ;
    endcase
  endtask

  // Load both thresholds, with a write to a spare slot in between
  task automatic program_thresholds(input logic [CfgW-1:0] long_ms,
                                    input logic [CfgW-1:0] win_ms);
    write_reg(CfgLongPress, long_ms);
    write_reg($urandom_range(1) ? CfgSpareHi : CfgSpareLo, CfgW'($urandom));
    write_reg(CfgWindow, win_ms);
    cfg_valid_i <= 1'b0;
  endtask

  // One press and release, quick taps half the time so multi-clicks happen
  task automatic send_gesture();
    int unsigned hold_step;
    int unsigned gap_step;
    int unsigned n_held;
    if ($urandom_range(1)) hold_step = window_ms_q / 4;
    else hold_step = long_ms_q / 2 + 1;
    gap_step = window_ms_q + window_ms_q / 2 + 1;
    n_held = $urandom_range(1, 4);
    repeat (n_held) begin
      send_sample(1'b0, t_ms);
      t_ms += $urandom_range(0, hold_step);
    end
    send_sample(1'b1, t_ms);
    if ($urandom_range(3) == 0) begin
      t_ms += $urandom_range(0, gap_step);
      send_sample(1'b1, t_ms);
    end
    t_ms += $urandom_range($urandom_range(1) ? window_ms_q / 2 : gap_step);
  endtask

  task automatic test_click_counting();
    idle_pct = 0;
    stall_pct = 0;
    send_sample(1'b1, 32'd0);
    send_sample(1'b0, 32'd100);
    send_sample(1'b1, 32'd200);
    send_sample(1'b0, 32'd300);
    send_sample(1'b1, 32'd400);
    send_sample(1'b0, 32'd450);
    send_sample(1'b1, 32'd500);
    // a fourth click saturates at triple
    send_sample(1'b0, 32'd550);
    send_sample(1'b1, 32'd600);
    // idle past the window clears the count
    send_sample(1'b1, 32'd1200);
    wait_for_results();
  endtask

  task automatic test_long_press();
    // long while held, then a silent release
    send_sample(1'b0, 32'd2000);
    send_sample(1'b0, 32'd5000);
    send_sample(1'b0, 32'd5100);
    send_sample(1'b1, 32'd5200);
    // long reported at release
    send_sample(1'b0, 32'd6000);
    send_sample(1'b1, 32'd9500);
    wait_for_results();
  endtask

  task automatic test_wrap_and_window_edge();
    send_sample(1'b0, 32'hFFFF_FFFF);
    send_sample(1'b1, 32'h0000_0010);
    // release gap equal to the window starts a new count
    send_sample(1'b0, 32'h0000_0020);
    send_sample(1'b1, 32'h0000_0010 + 32'd500);
    wait_for_results();
  endtask

  task automatic test_zero_threshold();
    program_thresholds('0, '1);
    send_sample(1'b0, 32'h8000_0000);
    send_sample(1'b1, 32'h8000_0001);
    send_sample(1'b0, 32'h8000_0002);
    send_sample(1'b1, 32'h8000_0003);
    wait_for_results();
  endtask

  task automatic test_random_traffic(input int unsigned idle, input int unsigned stall,
                                     input logic [CfgW-1:0] long_ms,
                                     input logic [CfgW-1:0] win_ms);
    int unsigned stop_at;
    program_thresholds(long_ms, win_ms);
    idle_pct = idle;
    stall_pct = stall;
    t_ms = $urandom;
    stop_at = sent_count + ItemsPerPhase;
    while (sent_count < stop_at) begin
      if ($urandom_range(7) == 0) begin
        // stray sample, sometimes with a far jump in time
        if ($urandom_range(3) == 0) t_ms = $urandom;
        else t_ms += $urandom_range(0, long_ms_q / 2 + 1);
        send_sample(1'($urandom_range(1)), t_ms);
      end else begin
        send_gesture();
      end
      if ($urandom_range(19) == 0) wait_for_results();
    end
    wait_for_results();
  endtask

  // Random backpressure on the result channel
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // Compare each accepted result beat with the oldest outcome due
  always @(posedge clk_i) begin
    outcome_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (due_outcomes.size() == 0) begin
        $error("result beat with no outcome due: press_kind %0d mode %0d",
               press_kind_o, mode_o);
        mismatch_count++;
      end else begin
        want = due_outcomes.pop_front();
        if (press_kind_o !== want.kind) begin
          $error("press_kind: expected %0d, got %0d", want.kind, press_kind_o);
          mismatch_count++;
        end
        if (mode_o !== want.mode) begin
          $error("mode: expected %0d, got %0d", want.mode, mode_o);
          mismatch_count++;
        end
        if (mode_changed_o !== want.changed) begin
          $error("mode_changed: expected %0d, got %0d", want.changed, mode_changed_o);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    button_level_i <= 1'b1;
    now_ms_i <= '0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= CfgLongPress;
    cfg_data_i <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_click_counting();
    test_long_press();
    test_wrap_and_window_edge();
    test_zero_threshold();
    test_random_traffic(0, 0, CfgW'(20), CfgW'(12));
    test_random_traffic(0, 0, '1, '1);
    test_random_traffic(81, 0, '1, '0);
    test_random_traffic(81, 0, CfgW'($urandom_range(1, 40)), CfgW'($urandom_range(1, 40)));
    test_random_traffic(0, 81, CfgW'(1), CfgW'(1));
    test_random_traffic(0, 81, CfgW'($urandom_range(1, 40)), CfgW'($urandom_range(1, 40)));
    test_random_traffic(25, 25, CfgW'($urandom), CfgW'($urandom));
    test_random_traffic(25, 25, CfgW'($urandom_range(1, 40)), CfgW'($urandom_range(1, 40)));

    // let any stray beat show up before the verdict
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("end of test: mismatches");
    $finish;
  end

endmodule
